FILE: rtl/dbtu_pkg.sv
// ----------------------------------------------------------------------------
// Depth buffer test unit package
// Shared sizes, request and register codes, and controller interface types.
// ----------------------------------------------------------------------------
package dbtu_pkg;

  // Buffer geometry and word sizes
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH_BITS = 24;
  localparam int COLOR_BITS = 24;

  localparam int NPIX    = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int XW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCNT_W  = $clog2(MAX_WIDTH + 1);
  localparam int HCNT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int MEM_W   = DEPTH_BITS + COLOR_BITS;

  // Request word fields
  localparam int REQ_W     = 2;
  localparam int COORD_W   = 12;
  localparam int FIELD_W   = 24;
  localparam int X_LSB     = 0;
  localparam int Y_LSB     = X_LSB + COORD_W;
  localparam int D_LSB     = Y_LSB + COORD_W;
  localparam int C_LSB     = D_LSB + FIELD_W;
  localparam int IN_DATA_W = ((C_LSB + FIELD_W + 7) / 8) * 8;

  // Result word: color, depth, in_bounds, was_written
  localparam int OUT_BITS   = FIELD_W + FIELD_W + 2;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Width used for bound compares, covers coordinates and active sizes
  localparam int CMP_W = COORD_W + 1;

  // Request codes; the spare code behaves as a read
  localparam logic [REQ_W-1:0] REQ_DRAW  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int DIM_W      = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_COLOR   = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // latch request, launch memory read
    logic eval_out;    // depth test, write back, load result
    logic sweep_step;  // write one cleared pixel, advance sweep
    logic clr_out;     // load result of a clear
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_is_clear;
    logic area_empty;
    logic sweep_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

FILE: rtl/dbtu_ctrl.sv
// ----------------------------------------------------------------------------
// Depth buffer test unit controller
// Sequences request intake, depth test, clear sweeps and result hand-off.
// ----------------------------------------------------------------------------
module dbtu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  dbtu_pkg::ctrl_sts_t sts_i,
  output dbtu_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_CLEAR = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      // Sweep the whole buffer once after reset
      S_INIT: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          if (!sts_i.in_is_clear) begin
            state_d = S_EVAL;
          end else if (sts_i.area_empty) begin
            state_d = S_DONE;
          end else begin
            state_d = S_CLEAR;
          end
        end
      end
      // Hold the read data until the result register frees
      S_EVAL: begin
        if (sts_i.out_free) begin
          cmd_o.eval_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.clr_out = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/dbtu_datapath.sv
// ----------------------------------------------------------------------------
// Depth buffer test unit datapath
// Configuration registers, pixel memory, depth compare, clear sweep counters
// and the result register.
// ----------------------------------------------------------------------------
module dbtu_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dbtu_pkg::ctrl_cmd_t                  cmd_i,
  output dbtu_pkg::ctrl_sts_t                  sts_o,
  input  logic                                 cfg_we_i,
  input  logic [dbtu_pkg::CFG_IDX_W-1:0]       cfg_addr_i,
  input  logic [dbtu_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic [dbtu_pkg::REQ_W-1:0]           s_tuser_i,
  input  logic [dbtu_pkg::IN_DATA_W-1:0]       s_tdata_i,
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  output logic [dbtu_pkg::OUT_DATA_W-1:0]      m_tdata_o
);

  localparam int CMP_W = dbtu_pkg::CMP_W;
  localparam int AW    = dbtu_pkg::ADDR_W;
  localparam int DB    = dbtu_pkg::DEPTH_BITS;
  localparam int CB    = dbtu_pkg::COLOR_BITS;

  // Configuration
  logic [dbtu_pkg::DIM_W-1:0] active_width_q, active_height_q;
  logic [CB-1:0]              clear_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_width_q  <= dbtu_pkg::DIM_RESET;
      active_height_q <= dbtu_pkg::DIM_RESET;
      clear_color_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        dbtu_pkg::CFG_ACTIVE_WIDTH:  active_width_q  <= cfg_wdata_i[dbtu_pkg::DIM_W-1:0];
        dbtu_pkg::CFG_ACTIVE_HEIGHT: active_height_q <= cfg_wdata_i[dbtu_pkg::DIM_W-1:0];
        dbtu_pkg::CFG_CLEAR_COLOR:   clear_color_q   <= cfg_wdata_i[CB-1:0];
        default: ;
      endcase
    end
  end

  // Effective active area, limited to the buffer size
  logic [dbtu_pkg::WCNT_W-1:0] eff_w;
  logic [dbtu_pkg::HCNT_W-1:0] eff_h;

  assign eff_w = (CMP_W'(active_width_q) > CMP_W'(dbtu_pkg::MAX_WIDTH)) ?
                 dbtu_pkg::WCNT_W'(dbtu_pkg::MAX_WIDTH) :
                 dbtu_pkg::WCNT_W'(active_width_q);
  assign eff_h = (CMP_W'(active_height_q) > CMP_W'(dbtu_pkg::MAX_HEIGHT)) ?
                 dbtu_pkg::HCNT_W'(dbtu_pkg::MAX_HEIGHT) :
                 dbtu_pkg::HCNT_W'(active_height_q);

  // Incoming word
  logic [dbtu_pkg::COORD_W-1:0] in_x, in_y;
  logic [DB-1:0]                in_depth;
  logic [CB-1:0]                in_color;
  logic                         in_inb;
  logic [AW-1:0]                in_addr;

  assign in_x     = s_tdata_i[dbtu_pkg::X_LSB +: dbtu_pkg::COORD_W];
  assign in_y     = s_tdata_i[dbtu_pkg::Y_LSB +: dbtu_pkg::COORD_W];
  assign in_depth = s_tdata_i[dbtu_pkg::D_LSB +: DB];
  assign in_color = s_tdata_i[dbtu_pkg::C_LSB +: CB];
  assign in_inb   = (CMP_W'(in_x) < CMP_W'(eff_w)) && (CMP_W'(in_y) < CMP_W'(eff_h));
  assign in_addr  = in_inb ? (AW'(in_y) * AW'(dbtu_pkg::MAX_WIDTH) + AW'(in_x)) : '0;

  // Request hold registers
  logic [dbtu_pkg::REQ_W-1:0] req_q;
  logic                       inb_q;
  logic [AW-1:0]              addr_q;
  logic [DB-1:0]              depth_q;
  logic [CB-1:0]              color_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q   <= s_tuser_i;
      inb_q   <= in_inb;
      addr_q  <= in_addr;
      depth_q <= in_depth;
      color_q <= in_color;
    end
  end

  // Clear sweep position
  logic [dbtu_pkg::XW-1:0] col_q, col_d;
  logic [dbtu_pkg::YW-1:0] row_q, row_d;
  logic                    last_col, last_row;
  logic [AW-1:0]           sweep_addr;

  assign last_col   = (dbtu_pkg::WCNT_W'(col_q) + dbtu_pkg::WCNT_W'(1)) == eff_w;
  assign last_row   = (dbtu_pkg::HCNT_W'(row_q) + dbtu_pkg::HCNT_W'(1)) == eff_h;
  assign sweep_addr = AW'(row_q) * AW'(dbtu_pkg::MAX_WIDTH) + AW'(col_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.sweep_step) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Pixel memory: {depth, color} per entry
  localparam int MEM_W_L = dbtu_pkg::MEM_W;
  logic [MEM_W_L-1:0] pix_mem [dbtu_pkg::NPIX];
  logic [MEM_W_L-1:0] rd_data_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [MEM_W_L-1:0] mem_wdata;

  logic [CB-1:0] st_color;
  logic [DB-1:0] st_depth;
  logic          pass;

  assign st_color = rd_data_q[0 +: CB];
  assign st_depth = rd_data_q[CB +: DB];
  assign pass     = (req_q == dbtu_pkg::REQ_DRAW) && inb_q &&
                    (depth_q != '0) && (depth_q < st_depth);

  assign mem_we    = cmd_i.sweep_step || (cmd_i.eval_out && pass);
  assign mem_waddr = cmd_i.sweep_step ? sweep_addr : addr_q;
  assign mem_wdata = cmd_i.sweep_step ? {{DB{1'b1}}, clear_color_q} : {depth_q, color_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pix_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.accept) begin
      rd_data_q <= pix_mem[in_addr];
    end
  end

  // Result register
  logic          out_valid_q, out_valid_d;
  logic [CB-1:0] out_color_q, res_color;
  logic [DB-1:0] out_depth_q, res_depth;
  logic          out_inb_q, res_inb;
  logic          out_wr_q, res_wr;
  logic          load;

  assign load = cmd_i.eval_out || cmd_i.clr_out;

  always_comb begin
    res_color = clear_color_q;
    res_depth = '1;
    res_inb   = inb_q;
    res_wr    = 1'b0;
    if (cmd_i.eval_out && inb_q) begin
      if (pass) begin
        res_color = color_q;
        res_depth = depth_q;
        res_wr    = 1'b1;
      end else begin
        res_color = st_color;
        res_depth = st_depth;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_color_q <= res_color;
      out_depth_q <= res_depth;
      out_inb_q   <= res_inb;
      out_wr_q    <= res_wr;
    end
  end

  assign out_valid_d = load ? 1'b1 : (m_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = dbtu_pkg::OUT_DATA_W'({out_wr_q, out_inb_q, out_depth_q, out_color_q});

  assign sts_o.in_is_clear = (s_tuser_i == dbtu_pkg::REQ_CLEAR);
  assign sts_o.area_empty  = (eff_w == '0) || (eff_h == '0);
  assign sts_o.sweep_last  = last_col && last_row;
  assign sts_o.out_free    = !out_valid_q || m_tready_i;

`ifndef SYNTHESIS
  a_write_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.eval_out && mem_we) |-> (depth_q != '0))
    else $error("depth write with zero depth");

  a_written_inb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_wr_q) |-> out_inb_q)
    else $error("written pixel reported out of bounds");

  a_sweep_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep_step |-> ((dbtu_pkg::WCNT_W'(col_q) < eff_w) &&
                          (dbtu_pkg::HCNT_W'(row_q) < eff_h)))
    else $error("clear sweep outside active area");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || m_tready_i))
    else $error("result loaded over a pending word");
`endif

endmodule

FILE: rtl/depth_buffer_test_unit_core.sv
// ----------------------------------------------------------------------------
// Depth buffer test unit
// Z-buffer with per-pixel color and depth: draw with depth test, read, clear.
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  s_*      | in        | tuser: req_type; tdata: request word
//  m_*      | out       | tdata: result word, one per request
//  cfg_*    | in        | write-only register port, no wait
//
//  Draw and read accept the word with a memory read, then do the depth
//  compare and write back on the single-write pixel memory.
//  Clear writes one pixel per cycle over the width * height active area.
//  After reset a clearing pass over the whole buffer runs with s_tready_o low.
//  One result waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module depth_buffer_test_unit_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dbtu_pkg::CFG_IDX_W-1:0]       cfg_addr_i,
  input  logic [dbtu_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 s_tvalid_i,
  output logic                                 s_tready_o,
  // req_type
  input  logic [dbtu_pkg::REQ_W-1:0]           s_tuser_i,
  // x_coord, y_coord, frag_depth, frag_color, zero pad
  input  logic [dbtu_pkg::IN_DATA_W-1:0]       s_tdata_i,
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  // pixel_color, pixel_depth, in_bounds, was_written, zero pad
  output logic [dbtu_pkg::OUT_DATA_W-1:0]      m_tdata_o
);

  dbtu_pkg::ctrl_cmd_t cmd;
  dbtu_pkg::ctrl_sts_t sts;

  dbtu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dbtu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tuser_i   (s_tuser_i),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o)
  );

endmodule

FILE: dv/depth_test_checker.sv
// ----------------------------------------------------------------------------
// Depth test checker
// Watches the config port and both streams of the depth buffer test unit.
// Keeps its own color and depth planes and the active area, works out the
// result word for every accepted request word, and compares each result
// word, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module depth_test_checker
  import dbtu_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  // req_type
  input  logic [REQ_W-1:0]       s_tuser_i,
  // x_coord, y_coord, frag_depth, frag_color, zero pad
  input  logic [IN_DATA_W-1:0]   s_tdata_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  // pixel_color, pixel_depth, in_bounds, was_written, zero pad
  input  logic [OUT_DATA_W-1:0]  m_tdata_i,
  output int unsigned            err_cnt_o,
  output int unsigned            pending_o
);

  typedef struct packed {
    logic [COLOR_BITS-1:0] color;
    logic [DEPTH_BITS-1:0] depth;
    logic                  inb;
    logic                  wr;
  } pixel_result_t;

  localparam logic [DEPTH_BITS-1:0] FAR_DEPTH = '1;

  logic [COLOR_BITS-1:0] color_plane [NPIX];
  logic [DEPTH_BITS-1:0] depth_plane [NPIX];
  logic [DIM_W-1:0]      area_w;
  logic [DIM_W-1:0]      area_h;
  logic [COLOR_BITS-1:0] clear_rgb;
  pixel_result_t         pixel_q [$];

  function automatic int clip_dim(input logic [DIM_W-1:0] dim, input int lim);
    return (int'(dim) > lim) ? lim : int'(dim);
  endfunction

  function automatic void fill_area(input int w, input int h);
    int a;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        a = r * MAX_WIDTH + c;
        color_plane[a] = clear_rgb;
        depth_plane[a] = FAR_DEPTH;
      end
    end
  endfunction

  function automatic pixel_result_t resolve_request(
    input logic [REQ_W-1:0]   req,
    input logic [COORD_W-1:0] x,
    input logic [COORD_W-1:0] y,
    input logic [FIELD_W-1:0] d,
    input logic [FIELD_W-1:0] col
  );
    pixel_result_t res;
    int            w;
    int            h;
    int            a;
    logic          inb;
    w   = clip_dim(area_w, MAX_WIDTH);
    h   = clip_dim(area_h, MAX_HEIGHT);
    inb = (int'(x) < w) && (int'(y) < h);
    a   = inb ? int'(y) * MAX_WIDTH + int'(x) : 0;
    res.wr = 1'b0;
    if (req == REQ_CLEAR) begin
      fill_area(w, h);
    end else if (req == REQ_DRAW && inb) begin
      // strict test: equal depth and the far depth never win
      if (d != '0 && d < depth_plane[a]) begin
        color_plane[a] = col;
        depth_plane[a] = d;
        res.wr = 1'b1;
      end
    end
    if (inb) begin
      res.color = color_plane[a];
      res.depth = depth_plane[a];
    end else begin
      res.color = clear_rgb;
      res.depth = FAR_DEPTH;
    end
    res.inb = inb;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      err_cnt_o++;
    end
  endfunction

  always @(posedge clk_i) begin : watch_b
    pixel_result_t got;
    pixel_result_t want;
    if (!rst_ni) begin
      area_w    = DIM_RESET;
      area_h    = DIM_RESET;
      clear_rgb = '0;
      fill_area(MAX_WIDTH, MAX_HEIGHT);
      pixel_q.delete();
      err_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_ACTIVE_WIDTH:  area_w    = cfg_wdata_i[DIM_W-1:0];
          CFG_ACTIVE_HEIGHT: area_h    = cfg_wdata_i[DIM_W-1:0];
          CFG_CLEAR_COLOR:   clear_rgb = cfg_wdata_i[COLOR_BITS-1:0];
          default: ;
        endcase
      end
      // compare before pushing: a word taken at this edge cannot be answered yet
      if (m_tvalid_i && m_tready_i) begin
        got.color = m_tdata_i[FIELD_W-1:0];
        got.depth = m_tdata_i[2*FIELD_W-1:FIELD_W];
        got.inb   = m_tdata_i[2*FIELD_W];
        got.wr    = m_tdata_i[2*FIELD_W+1];
        if (pixel_q.size() == 0) begin
          $error("result word %0h with no request outstanding", m_tdata_i);
          err_cnt_o++;
        end else begin
          want = pixel_q.pop_front();
          check_field("pixel_color", 32'(want.color), 32'(got.color));
          check_field("pixel_depth", 32'(want.depth), 32'(got.depth));
          check_field("in_bounds", 32'(want.inb), 32'(got.inb));
          check_field("was_written", 32'(want.wr), 32'(got.wr));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        pixel_q.push_back(resolve_request(s_tuser_i,
                                          s_tdata_i[X_LSB +: COORD_W],
                                          s_tdata_i[Y_LSB +: COORD_W],
                                          s_tdata_i[D_LSB +: FIELD_W],
                                          s_tdata_i[C_LSB +: FIELD_W]));
      end
    end
    pending_o = pixel_q.size();
  end

endmodule

FILE: dv/tb_depth_buffer_test_unit_core.sv
// ----------------------------------------------------------------------------
// Depth buffer test unit testbench
// Drives draw, read and clear request words through the unit under several
// active areas and clear colors: a directed pass over the depth test edges,
// clear scope and out-of-bounds behavior, then random phases with bursty
// input and a stalling output. A checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_depth_buffer_test_unit_core;
  import dbtu_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 400;
  localparam int CLEAR_AREA_MAX = 4096;
  localparam int PHASE_WORDS    = 170;
  localparam int NUM_PHASES     = 10;
  // full-area clear and the clearing pass after reset leave both streams idle
  localparam int WATCHDOG_LIMIT = 300000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_tvalid_i;
  logic                  s_tready_o;
  logic [REQ_W-1:0]      s_tuser_i;
  logic [IN_DATA_W-1:0]  s_tdata_i;
  logic                  m_tvalid_o;
  logic                  m_tready_i;
  logic [OUT_DATA_W-1:0] m_tdata_o;

  int unsigned err_cnt;
  int unsigned pending;

  int cur_w;
  int cur_h;
  int burst_left;
  int hold_reqs;

  int phase_w [NUM_PHASES] = '{16, 1, 256, 8, 0, 100, 511, 3, 256, 37};
  int phase_h [NUM_PHASES] = '{16, 1, 8, 256, 100, 0, 4, 511, 256, 53};

  depth_buffer_test_unit_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tuser_i   (s_tuser_i),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o)
  );

  depth_test_checker u_depth_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_i  (s_tready_o),
    .s_tuser_i   (s_tuser_i),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_i  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_i   (m_tdata_o),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offer one request word and hold it until the unit takes it.
  task automatic offer_word(input logic [REQ_W-1:0] req, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [FIELD_W-1:0] d,
                            input logic [FIELD_W-1:0] col);
    @(negedge clk_i);
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= req;
    s_tdata_i  <= {col, d, y, x};
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic reconfigure(input int w, input int h, input logic [COLOR_BITS-1:0] rgb);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    set_reg(CFG_ACTIVE_WIDTH, CFG_DATA_W'(w));
    set_reg(CFG_ACTIVE_HEIGHT, CFG_DATA_W'(h));
    set_reg(CFG_CLEAR_COLOR, rgb);
    cur_w = (w > MAX_WIDTH) ? MAX_WIDTH : w;
    cur_h = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
  endtask

  // Mostly in bounds, with a hot corner so draws land on the same pixels.
  function automatic logic [COORD_W-1:0] pick_coord(input int lim);
    int r;
    r = $urandom_range(99);
    if (lim == 0 || r < 15) return COORD_W'($urandom_range(2**COORD_W - 1));
    if (r < 25) return COORD_W'(lim - 1 + int'($urandom_range(1)));
    if (r < 60) return COORD_W'($urandom_range((lim < 4) ? lim - 1 : 3));
    return COORD_W'($urandom_range(lim - 1));
  endfunction

  function automatic logic [FIELD_W-1:0] pick_depth();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 50) return FIELD_W'($urandom_range(2**FIELD_W - 1));
    return FIELD_W'($urandom_range(4096, 1));
  endfunction

  task automatic run_random(input int n, input bit do_hold, input bit do_drain);
    int               r;
    logic [REQ_W-1:0] req;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 1);
        if ($urandom_range(3) != 0) pause_sender($urandom_range(8, 1));
      end
      burst_left--;
      if (do_hold && i == n / 2) hold_reqs++;
      if (do_drain && i == n / 2) drain_results();
      r = $urandom_range(99);
      if (r < 55)      req = REQ_DRAW;
      else if (r < 85) req = REQ_READ;
      else if (r < 90) req = REQ_SPARE;
      else if (cur_w * cur_h <= CLEAR_AREA_MAX) req = REQ_CLEAR;
      else             req = REQ_DRAW;
      offer_word(req, pick_coord(cur_w), pick_coord(cur_h), pick_depth(),
                 FIELD_W'($urandom_range(2**FIELD_W - 1)));
    end
  endtask

  // Result side: stall on shifting modes, or hold off when asked.
  initial begin : result_sink
    int mode;
    int mode_left;
    int hold_seen;
    mode       = 0;
    mode_left  = 0;
    hold_seen  = 0;
    m_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        m_tready_i <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(2);
          mode_left = $urandom_range(200, 20);
        end
        mode_left--;
        case (mode)
          0:       m_tready_i <= 1'b1;
          1:       m_tready_i <= 1'($urandom_range(1));
          default: m_tready_i <= ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = CFG_ACTIVE_WIDTH;
    cfg_wdata_i = '0;
    s_tvalid_i  = 1'b0;
    s_tuser_i   = REQ_READ;
    s_tdata_i   = '0;
    cur_w       = MAX_WIDTH;
    cur_h       = MAX_HEIGHT;
    burst_left  = 0;
    hold_reqs   = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Depth test edges from the reset contents, mostly at the origin
    offer_word(REQ_READ, 0, 0, 0, 0);
    offer_word(REQ_DRAW, 0, 0, 0, 24'h00FF00);
    offer_word(REQ_DRAW, 0, 0, 24'hFFFFFF, 24'h0000FF);
    offer_word(REQ_DRAW, 0, 0, 24'd100, 24'hABCDEF);
    offer_word(REQ_DRAW, 0, 0, 24'd100, 24'h111111);
    offer_word(REQ_DRAW, 0, 0, 24'd99, 24'h222222);
    offer_word(REQ_DRAW, 255, 255, 24'd1, 24'hFFFFFF);
    offer_word(REQ_DRAW, 256, 0, 24'd5, 24'h333333);
    offer_word(REQ_READ, 12'hFFF, 12'hFFF, 24'hFFFFFF, 24'hFFFFFF);
    offer_word(REQ_SPARE, 0, 255, 24'd5, 24'h444444);
    offer_word(REQ_DRAW, 5, 5, 24'd5, 24'h555555);
    offer_word(REQ_DRAW, 1, 1, 24'hFFFFFE, 24'h666666);

    // New clear color leaves the planes alone; clear only the 2x2 corner
    reconfigure(2, 2, 24'h123456);
    offer_word(REQ_READ, 0, 0, 0, 0);
    offer_word(REQ_READ, 2, 0, 0, 0);
    offer_word(REQ_CLEAR, 1, 1, 0, 0);

    // Oversized area clips to the full grid; pixel outside the old clear kept
    reconfigure(511, 511, 24'h123456);
    offer_word(REQ_READ, 5, 5, 0, 0);
    offer_word(REQ_READ, 0, 0, 0, 0);
    offer_word(REQ_READ, 256, 0, 0, 0);
    offer_word(REQ_READ, 0, 256, 0, 0);
    offer_word(REQ_CLEAR, 255, 255, 24'd7, 24'h777777);
    offer_word(REQ_READ, 5, 5, 0, 0);

    // Zero width: nothing in bounds, clear writes nothing
    reconfigure(0, 256, 24'hFFFFFF);
    offer_word(REQ_CLEAR, 0, 0, 0, 0);
    offer_word(REQ_DRAW, 0, 0, 24'd1, 24'h888888);

    for (int p = 0; p < NUM_PHASES; p++) begin
      reconfigure(phase_w[p], phase_h[p],
                  (p == 1) ? 24'hFFFFFF : (p == 4) ? 24'h000000
                                                   : 24'($urandom_range(2**COLOR_BITS - 1)));
      run_random(PHASE_WORDS, p == 2, p == 5);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
